### rtl/core/dsls_pkg.sv
// Shared types, constants and helpers for the dot-stuffed line splitter.
// No dependencies; every other file of the block imports this package.
package dsls_pkg;

  // Line store geometry
  localparam int LINE_CAP   = 8192;
  localparam int ADDR_W     = $clog2(LINE_CAP);
  localparam int LEN_W      = $clog2(LINE_CAP + 1);
  localparam int BYTE_W     = 8;

  // Configuration port
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 14;
  localparam logic [CFG_ADDR_W-1:0] REG_FORMAT_MODE = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_LINE_LIMIT  = 1'd1;

  // Limit range
  localparam logic [LEN_W-1:0] LIMIT_MIN = LEN_W'(4);
  localparam logic [LEN_W-1:0] LIMIT_MAX = LEN_W'(LINE_CAP);

  // Character codes
  localparam logic [BYTE_W-1:0] CH_LF  = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR  = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_DOT = 8'h2E;

  // Item modes
  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_READ = 1'b1;

  // Result kinds
  typedef enum logic [2:0] {
    KIND_BYTE     = 3'd0,
    KIND_LINE     = 3'd1,
    KIND_END      = 3'd2,
    KIND_TOO_LONG = 3'd3,
    KIND_READ     = 3'd4
  } kind_t;

  // Line store access issued with an accepted item
  typedef struct packed {
    logic              wr_en;
    logic              rd_en;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] wdata;
  } mem_req_t;

  // Result of one item, apart from the read data
  typedef struct packed {
    kind_t            kind;
    logic [LEN_W-1:0] line_length;
    logic             skip_first;
    logic             wire_known;
    logic             wire_active;
  } res_t;

  // Saturate a written limit to the supported range
  function automatic logic [LEN_W-1:0] clamp_limit(input logic [CFG_DATA_W-1:0] v);
    logic [LEN_W-1:0] lim;
    lim = LEN_W'(v);
    if (lim < LIMIT_MIN) begin
      lim = LIMIT_MIN;
    end else if (lim > LIMIT_MAX) begin
      lim = LIMIT_MAX;
    end
    return lim;
  endfunction

endpackage

### rtl/core/dsls_in_if.sv
// Input channel of the line splitter: valid/ready plus one input item.
// Depends on dsls_pkg for field widths.
interface dsls_in_if import dsls_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              mode;
  logic [BYTE_W-1:0] stream_byte;
  logic [ADDR_W-1:0] read_index;

  modport source (output valid, mode, stream_byte, read_index, input ready);
  modport sink   (input valid, mode, stream_byte, read_index, output ready);
endinterface

### rtl/core/dsls_out_if.sv
// Result channel of the line splitter: valid/ready plus one result item.
// Depends on dsls_pkg for field widths.
interface dsls_out_if import dsls_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [2:0]        kind;
  logic [LEN_W-1:0]  line_length;
  logic              skip_first;
  logic [BYTE_W-1:0] read_byte;
  logic              wire_known;
  logic              wire_active;

  modport source (output valid, kind, line_length, skip_first, read_byte, wire_known,
                  wire_active, input ready);
  modport sink   (input valid, kind, line_length, skip_first, read_byte, wire_known,
                  wire_active, output ready);
endinterface

### rtl/core/dsls_cfg_if.sv
// Configuration write channel: valid/ready, register index and write data.
// Depends on dsls_pkg for field widths.
interface dsls_cfg_if import dsls_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

### rtl/core/dsls_line_store.sv
// Line store: single-port synchronous RAM, one write or one read per cycle.
// Read data is registered and held until the next read. Depends on dsls_pkg.
module dsls_line_store import dsls_pkg::*; (
  input  logic              clk,
  input  mem_req_t          req,
  output logic [BYTE_W-1:0] rdata
);

  logic [BYTE_W-1:0] mem [LINE_CAP];
  logic [BYTE_W-1:0] rdata_r;

  // Write stream bytes
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr] <= req.wdata;
    end
  end

  // Read and hold
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rdata_r <= mem[req.addr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/core/dsls_framer.sv
// Framing control: configuration registers, fill count, format decision and
// line-end detection for each accepted item. Depends on dsls_pkg.
module dsls_framer import dsls_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  dsls_cfg_if.sink          cfg_ch,
  input  logic              accept,
  input  logic              mode,
  input  logic [BYTE_W-1:0] stream_byte,
  input  logic [ADDR_W-1:0] read_index,
  output mem_req_t          mem_req,
  output res_t              res
);

  logic             fmt_r, fmt_nxt;
  logic [LEN_W-1:0] lim_r, lim_nxt;
  logic [LEN_W-1:0] fill_r, fill_nxt;
  logic             decided_r, decided_nxt;
  logic             wire_r, wire_nxt;
  logic             last_cr_r, last_cr_nxt;
  logic             first_dot_r, first_dot_nxt;

  logic             push;
  logic             cfg_acc;
  logic [LEN_W-1:0] fill0;
  logic [LEN_W-1:0] fill1;
  logic [LEN_W-1:0] base_len;
  logic [LEN_W-1:0] dot_len;
  logic             prev_cr;
  logic             is_lf;
  logic             first_dot;
  logic             decide;
  logic             wire_now;
  logic             done;
  logic             too_long;

  assign cfg_ch.ready = 1'b1;
  assign cfg_acc      = cfg_ch.valid & cfg_ch.ready;
  assign push         = accept & (mode == MODE_PUSH);

  // Configuration writes
  always_comb begin
    fmt_nxt = fmt_r;
    lim_nxt = lim_r;
    if (cfg_acc) begin
      case (cfg_ch.addr)
        REG_FORMAT_MODE: fmt_nxt = cfg_ch.data[0];
        REG_LINE_LIMIT:  lim_nxt = clamp_limit(cfg_ch.data);
        default:         fmt_nxt = fmt_r;
      endcase
    end
  end

  // Frame the pushed byte
  always_comb begin
    fill0     = (fill_r >= lim_r) ? '0 : fill_r;
    fill1     = fill0 + LEN_W'(1);
    prev_cr   = (fill0 != '0) && last_cr_r;
    is_lf     = (stream_byte == CH_LF);
    first_dot = (fill0 == '0) ? (stream_byte == CH_DOT) : first_dot_r;
    decide    = is_lf && !fmt_r && !decided_r;
    wire_now  = fmt_r | (decide ? prev_cr : wire_r);
    done      = is_lf && (!wire_now || prev_cr);
    base_len  = wire_now ? (fill0 - LEN_W'(1)) : fill0;
    dot_len   = base_len - LEN_W'(1);
    too_long  = !done && (fill1 >= lim_r);
  end

  // Build the result
  always_comb begin
    res.kind        = KIND_BYTE;
    res.line_length = '0;
    res.skip_first  = 1'b0;
    if (mode == MODE_READ) begin
      res.kind = KIND_READ;
    end else if (done) begin
      if (wire_now && first_dot) begin
        if (dot_len != '0) begin
          res.kind        = KIND_LINE;
          res.line_length = dot_len;
          res.skip_first  = 1'b1;
        end else begin
          res.kind = KIND_END;
        end
      end else begin
        res.kind        = KIND_LINE;
        res.line_length = base_len;
      end
    end else if (too_long) begin
      res.kind = KIND_TOO_LONG;
    end
    res.wire_known  = fmt_r | decided_nxt;
    res.wire_active = fmt_r | (decided_nxt & wire_nxt);
  end

  // Advance line state on a pushed byte
  always_comb begin
    fill_nxt      = fill_r;
    decided_nxt   = decided_r;
    wire_nxt      = wire_r;
    last_cr_nxt   = last_cr_r;
    first_dot_nxt = first_dot_r;
    if (push) begin
      fill_nxt      = (done || too_long) ? '0 : fill1;
      last_cr_nxt   = (stream_byte == CH_CR);
      first_dot_nxt = first_dot;
      if (decide) begin
        decided_nxt = 1'b1;
        wire_nxt    = prev_cr;
      end
    end
  end

  // Line store access
  always_comb begin
    mem_req.wr_en = push;
    mem_req.rd_en = accept & (mode == MODE_READ);
    mem_req.addr  = (mode == MODE_READ) ? read_index : fill0[ADDR_W-1:0];
    mem_req.wdata = stream_byte;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r       <= 1'b0;
      lim_r       <= LIMIT_MAX;
      fill_r      <= '0;
      decided_r   <= 1'b0;
      wire_r      <= 1'b0;
      last_cr_r   <= 1'b0;
      first_dot_r <= 1'b0;
    end else begin
      fmt_r       <= fmt_nxt;
      lim_r       <= lim_nxt;
      fill_r      <= fill_nxt;
      decided_r   <= decided_nxt;
      wire_r      <= wire_nxt;
      last_cr_r   <= last_cr_nxt;
      first_dot_r <= first_dot_nxt;
    end
  end

`ifndef SYNTH
  // Fill count never passes the store capacity
  a_fill_cap: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= LIMIT_MAX)
    else $error("fill count beyond line store capacity");

  // A too-long line is dropped: fill restarts at zero
  a_too_long_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (push && res.kind == KIND_TOO_LONG) |=> (fill_r == '0))
    else $error("fill count not cleared after too-long line");

  // Once guessed, the format decision sticks
  a_decided_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    decided_r |=> decided_r)
    else $error("format decision lost");

  // A finished line leaves the fill count at zero
  a_line_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (push && (res.kind == KIND_LINE || res.kind == KIND_END)) |=> (fill_r == '0))
    else $error("fill count not cleared after line end");
`endif

endmodule

### rtl/core/dsls_out_buf.sv
// Result buffering: a stage aligned with the line store read, then the
// output register, so an item is taken while a result waits. Depends on dsls_pkg.
module dsls_out_buf import dsls_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  res_t              res,
  input  logic [BYTE_W-1:0] rdata,
  dsls_out_if.source        out_ch
);

  logic              s1_v_r, s1_v_nxt;
  res_t              s1_res_r;
  logic              out_v_r, out_v_nxt;
  res_t              out_res_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic              accept;
  logic              s1_adv;

  // Stage one moves on when the output register is free or being drained
  assign s1_adv   = !out_v_r || out_ch.ready;
  assign in_ready = !s1_v_r || s1_adv;
  assign accept   = in_valid & in_ready;

  assign s1_v_nxt  = accept | (s1_v_r & !s1_adv);
  assign out_v_nxt = (s1_v_r & s1_adv) | (out_v_r & !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // Capture payloads; read data joins the item in the output register
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_res_r <= res;
    end
    if (s1_v_r && s1_adv) begin
      out_res_r  <= s1_res_r;
      out_byte_r <= (s1_res_r.kind == KIND_READ) ? rdata : '0;
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.kind        = out_res_r.kind;
  assign out_ch.line_length = out_res_r.line_length;
  assign out_ch.skip_first  = out_res_r.skip_first;
  assign out_ch.read_byte   = out_byte_r;
  assign out_ch.wire_known  = out_res_r.wire_known;
  assign out_ch.wire_active = out_res_r.wire_active;

`ifndef SYNTH
  // A stalled output keeps the item in stage one
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && out_v_r && !out_ch.ready) |=> s1_v_r)
    else $error("stage one item lost under stall");

  // No item is taken while both stages are full and stalled
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && out_v_r && !out_ch.ready) |-> !accept)
    else $error("item accepted into a full buffer");

  // Every item in stage one reaches the output register
  a_s1_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && s1_adv) |=> out_v_r)
    else $error("stage one item not delivered");
`endif

endmodule

### rtl/core/dot_stuffed_line_splitter.sv
// Dot-stuffed line splitter, top level.
// A result passes through stage one and then the output register after its item is accepted.
// Throughput: one item per cycle unless out_ch stalls; each byte costs one line store write and
// each read one line store read, on the single RAM port.
// Reset (rst_n, synchronous): format guess cleared, limit 8192, fill count
// zero; the line store keeps its contents and needs no clearing pass.
module dot_stuffed_line_splitter import dsls_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  dsls_in_if.sink    in_ch,
  dsls_out_if.source out_ch,
  dsls_cfg_if.sink   cfg_ch
);

  mem_req_t          mem_req;
  res_t              res;
  logic [BYTE_W-1:0] rdata;
  logic              accept;

  // Hand the item to the framer once the buffer can take it
  assign accept = in_ch.valid & in_ch.ready;

  dsls_framer u_framer (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_ch      (cfg_ch),
    .accept      (accept),
    .mode        (in_ch.mode),
    .stream_byte (in_ch.stream_byte),
    .read_index  (in_ch.read_index),
    .mem_req     (mem_req),
    .res         (res)
  );

  dsls_line_store u_store (
    .clk   (clk),
    .req   (mem_req),
    .rdata (rdata)
  );

  dsls_out_buf u_out_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .res      (res),
    .rdata    (rdata),
    .out_ch   (out_ch)
  );

endmodule
